// ===== sv/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// vna_pkg - shared constants and types
// Widths, operation codes and the multiplier request bundle of the
// vertex normal accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package vna_pkg;

    localparam int VERTEX_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
    localparam int IDX_W        = 10;
    localparam int POS_W        = 24;
    localparam int NRM_W        = 16;
    localparam int DIFF_W       = POS_W + 1;
    localparam int VEC_W        = 50;
    localparam int MAG_W        = 50;
    localparam int MUL_W        = 31;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int SUM_W        = 62;
    localparam int ROOT_W       = 63;
    localparam int LEN_W        = 31;
    localparam int QUO_W        = 15;
    localparam int NUM_W        = 45;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TRI  = 1'b1;

    typedef struct packed {
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } t_mul_req;

endpackage

`default_nettype wire

// ===== sv/vna_mul.sv =====
// ----------------------------------------------------------------------------
// vna_mul - shared registered multiplier
// Signed multiply with the product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_mul (
    input  wire logic                                i_clk,
    input  wire vna_pkg::t_mul_req                   i_req,
    output logic signed [vna_pkg::PROD_W-1:0]        o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= i_req.a * i_req.b;
    end

endmodule

`default_nettype wire

// ===== sv/vna_norm.sv =====
// ----------------------------------------------------------------------------
// vna_norm - iterative vector normalizer
// Scales a 3-vector to unit length in Q1.14: shift search, sum of squares
// on the shared multiplier, bit-serial square root and restoring division.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_norm (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_start,
    input  wire logic signed [vna_pkg::VEC_W-1:0]        i_vec [3],
    output logic                                         o_done,
    output logic signed [vna_pkg::NRM_W-1:0]             o_res [3],
    output vna_pkg::t_mul_req                            o_mul,
    input  wire logic signed [vna_pkg::PROD_W-1:0]       i_mul_p
);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_SQRT  = 3'd3;
    localparam logic [2:0] N_DLOAD = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;

    localparam logic [vna_pkg::MAG_W-1:0] LIM_R8 = vna_pkg::MAG_W'(1) << 38;
    localparam logic [vna_pkg::MAG_W-1:0] LIM_R1 = vna_pkg::MAG_W'(1) << 30;
    localparam logic [vna_pkg::MAG_W-1:0] LIM_L1 = vna_pkg::MAG_W'(1) << 29;
    localparam logic [vna_pkg::MAG_W-1:0] LIM_L8 = vna_pkg::MAG_W'(1) << 21;

    logic [2:0]                      r_state;
    logic                            r_neg [3];
    logic [vna_pkg::MAG_W-1:0]       r_mag [3];
    logic [3:0]                      r_cnt;
    logic [1:0]                      r_idx;
    logic [vna_pkg::SUM_W-1:0]       r_sum;
    logic [vna_pkg::SUM_W-1:0]       r_v;
    logic [vna_pkg::ROOT_W-1:0]      r_root;
    logic [vna_pkg::ROOT_W-1:0]      r_bit;
    logic [vna_pkg::LEN_W-1:0]       r_len;
    logic [vna_pkg::LEN_W:0]         r_rem;
    logic [vna_pkg::QUO_W-1:0]       r_num;
    logic [vna_pkg::QUO_W-1:0]       r_quo;
    logic                            r_done;
    logic signed [vna_pkg::NRM_W-1:0] r_res [3];

    logic [vna_pkg::MAG_W-1:0]       w_abs [3];
    logic [vna_pkg::MAG_W-1:0]       w_max;
    logic [vna_pkg::ROOT_W-1:0]      w_trial;
    logic [vna_pkg::NUM_W-1:0]       w_num;
    logic [vna_pkg::LEN_W:0]         w_t;
    logic                            w_ge;
    logic [vna_pkg::QUO_W-1:0]       w_q;
    logic [vna_pkg::MUL_W-1:0]       w_sq_op;
    logic                            w_fin;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = i_vec[i][vna_pkg::VEC_W-1] ? vna_pkg::MAG_W'(-i_vec[i])
                                                 : vna_pkg::MAG_W'(i_vec[i]);
        end
        w_max = r_mag[0];
        if (r_mag[1] > w_max) w_max = r_mag[1];
        if (r_mag[2] > w_max) w_max = r_mag[2];
        w_trial = r_root + r_bit;
        w_num   = {r_mag[r_idx][29:0], 14'd0} + vna_pkg::NUM_W'(r_len >> 1);
        w_t     = {r_rem[vna_pkg::LEN_W-1:0], r_num[vna_pkg::QUO_W-1]};
        w_ge    = w_t >= {1'b0, r_len};
        w_q     = {r_quo[vna_pkg::QUO_W-2:0], w_ge};
        w_sq_op = (r_cnt < 4'd3) ? {1'b0, r_mag[r_cnt[1:0]][29:0]} : '0;
        // finish on a zero vector at start, or after the last quotient bit
        w_fin   = ((r_state == N_IDLE) && i_start && w_abs[0] == '0
                   && w_abs[1] == '0 && w_abs[2] == '0)
                || ((r_state == N_DIV) && (r_cnt == 4'(vna_pkg::QUO_W - 1))
                   && (r_idx == 2'd2));
    end

    assign o_mul.a = w_sq_op;
    assign o_mul.b = w_sq_op;
    assign o_done  = r_done;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_fin;
            case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_neg[i] <= i_vec[i][vna_pkg::VEC_W-1];
                            r_mag[i] <= w_abs[i];
                        end
                        if (w_abs[0] == '0 && w_abs[1] == '0 && w_abs[2] == '0) begin
                            for (int i = 0; i < 3; i++) r_res[i] <= '0;
                        end else begin
                            r_state <= N_SHIFT;
                        end
                    end
                end
                N_SHIFT: begin
                    if (w_max >= LIM_R8) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 8;
                    end else if (w_max >= LIM_R1) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else if (w_max < LIM_L8) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 8;
                    end else if (w_max < LIM_L1) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    // issue one square a cycle, accumulate the one from last cycle
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt != '0) r_sum <= r_sum + vna_pkg::SUM_W'(i_mul_p);
                    if (r_cnt == 4'd3) begin
                        r_v     <= r_sum + vna_pkg::SUM_W'(i_mul_p);
                        r_root  <= '0;
                        r_bit   <= vna_pkg::ROOT_W'(1) << 62;
                        r_state <= N_SQRT;
                    end
                end
                N_SQRT: begin
                    if (r_bit == '0) begin
                        r_len   <= r_root[vna_pkg::LEN_W-1:0];
                        r_idx   <= '0;
                        r_state <= N_DLOAD;
                    end else begin
                        if ({1'b0, r_v} >= w_trial) begin
                            r_v    <= r_v - vna_pkg::SUM_W'(w_trial);
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                N_DLOAD: begin
                    r_rem   <= (vna_pkg::LEN_W + 1)'(w_num[vna_pkg::NUM_W-1:vna_pkg::QUO_W]);
                    r_num   <= w_num[vna_pkg::QUO_W-1:0];
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    r_rem <= w_ge ? (w_t - {1'b0, r_len}) : w_t;
                    r_quo <= w_q;
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(vna_pkg::QUO_W - 1)) begin
                        r_res[r_idx] <= r_neg[r_idx] ? -vna_pkg::NRM_W'(w_q)
                                                     : vna_pkg::NRM_W'(w_q);
                        if (r_idx == 2'd2) begin
                            r_state <= N_IDLE;
                        end else begin
                            r_idx   <= r_idx + 2'd1;
                            r_state <= N_DLOAD;
                        end
                    end
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/vertex_normal_accumulator.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_accumulator - per-vertex normal accumulation
// Vertex store with face-normal cross product and iterative renormalization.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel. tuser selects the operation: a load
//   writes one vertex (position and starting normal) into slot corner_a and
//   returns nothing; a triangle reads corners a, b and c, forms the face
//   normal cross(b-a, c-a) with y negated, normalizes it, then for each
//   corner in order adds it to the stored normal, normalizes, writes it back
//   and emits one result on m_axis. tlast marks the third corner result.
//   Sequencing: a load is written in the cycle it is accepted. A triangle runs
//   four normalizations, each set by the 32-step square root and the 15-step
//   divider per component in the normalizer, with cross products and squares
//   on one shared multiplier. s_axis_tready is low for the whole triangle.
//   Reset clears the control state only; vertex stores hold garbage until a
//   slot is loaded, and triangles must only name loaded slots.
//   A stalled receiver holds the result in the output register and the
//   sequencer waits before the next corner; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_normal_accumulator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // corner_a, corner_b, corner_c, pos_x, pos_y, pos_z,
    // init_normal_x, init_normal_y, init_normal_z, zero pad
    input  wire logic [151:0]  s_axis_tdata,
    // operation
    input  wire logic          s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // vertex_slot, new_normal_x, new_normal_y, new_normal_z, zero pad
    output logic [63:0]        m_axis_tdata,
    output logic               m_axis_tlast
);

    localparam int AW = vna_pkg::ADDR_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD0   = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_RD2   = 4'd3;
    localparam logic [3:0] S_RD3   = 4'd4;
    localparam logic [3:0] S_DIFF  = 4'd5;
    localparam logic [3:0] S_CROSS = 4'd6;
    localparam logic [3:0] S_FACE  = 4'd7;
    localparam logic [3:0] S_NRD   = 4'd8;
    localparam logic [3:0] S_NCAP  = 4'd9;
    localparam logic [3:0] S_NSUM  = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    // vertex stores: position {z,y,x} and normal {z,y,x}
    logic [3*vna_pkg::POS_W-1:0] pos_mem [vna_pkg::VERTEX_DEPTH];
    logic [3*vna_pkg::NRM_W-1:0] nrm_mem [vna_pkg::VERTEX_DEPTH];

    logic [3:0]                        r_state;
    logic [AW-1:0]                     r_slot [3];
    logic [1:0]                        r_corner;
    logic [2:0]                        r_cnt;
    logic [3*vna_pkg::POS_W-1:0]       r_pos_rd;
    logic [3*vna_pkg::NRM_W-1:0]       r_nrm_rd;
    logic [3*vna_pkg::POS_W-1:0]       r_pa, r_pb, r_pc;
    logic signed [vna_pkg::DIFF_W-1:0] r_d1 [3];
    logic signed [vna_pkg::DIFF_W-1:0] r_d2 [3];
    logic signed [vna_pkg::VEC_W-1:0]  r_tmp;
    logic signed [vna_pkg::VEC_W-1:0]  r_nvec [3];
    logic                              r_nstart;
    logic signed [vna_pkg::NRM_W-1:0]  r_face [3];
    logic                              r_out_valid;
    logic [63:0]                       r_out_data;
    logic                              r_out_last;
    logic [63:0]                       r_m_data;
    logic                              r_m_last;

    logic                              w_in_acc;
    logic                              w_load;
    logic [AW-1:0]                     w_in_slot;
    logic [AW-1:0]                     w_pos_raddr;
    logic                              w_nrm_we;
    logic [AW-1:0]                     w_nrm_waddr;
    logic [3*vna_pkg::NRM_W-1:0]       w_nrm_wdata;
    logic                              w_out_free;
    logic                              w_emit;
    logic                              w_nstart;
    vna_pkg::t_mul_req                 w_cross_req;
    vna_pkg::t_mul_req                 w_norm_req;
    vna_pkg::t_mul_req                 w_mul_req;
    logic signed [vna_pkg::PROD_W-1:0] w_prod;
    logic signed [vna_pkg::VEC_W-1:0]  w_prod_v;
    logic                              w_ndone;
    logic signed [vna_pkg::NRM_W-1:0]  w_nres [3];
    logic [2:0]                        w_prev;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_in_acc && (s_axis_tuser == vna_pkg::OP_LOAD);
    assign w_in_slot     = AW'(s_axis_tdata[9:0] % vna_pkg::VERTEX_DEPTH);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_emit        = (r_state == S_EMIT) && w_out_free;
    // start the normalizer after the last cross product and after each corner sum
    assign w_nstart      = ((r_state == S_CROSS) && (r_cnt == 3'd6)) || (r_state == S_NCAP);
    assign w_prod_v      = w_prod[vna_pkg::VEC_W-1:0];
    assign w_prev        = r_cnt - 3'd1;

    // read address for the corner positions
    always_comb begin
        case (r_state)
            S_RD1:   w_pos_raddr = r_slot[1];
            S_RD2:   w_pos_raddr = r_slot[2];
            default: w_pos_raddr = r_slot[0];
        endcase
    end

    // normal store has one write port: loads and corner write-back
    always_comb begin
        if (w_load) begin
            w_nrm_we    = 1'b1;
            w_nrm_waddr = w_in_slot;
            w_nrm_wdata = s_axis_tdata[149:102];
        end else begin
            w_nrm_we    = (r_state == S_NSUM) && w_ndone;
            w_nrm_waddr = r_slot[r_corner];
            w_nrm_wdata = {w_nres[2], w_nres[1], w_nres[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) pos_mem[w_in_slot] <= s_axis_tdata[101:30];
        r_pos_rd <= pos_mem[w_pos_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_nrm_we) nrm_mem[w_nrm_waddr] <= w_nrm_wdata;
        r_nrm_rd <= nrm_mem[r_slot[r_corner]];
    end

    // cross product operand schedule: six products, paired by subtraction
    always_comb begin
        case (r_cnt)
            3'd0:    begin w_cross_req.a = vna_pkg::MUL_W'(r_d1[1]);
                           w_cross_req.b = vna_pkg::MUL_W'(r_d2[2]); end
            3'd1:    begin w_cross_req.a = vna_pkg::MUL_W'(r_d1[2]);
                           w_cross_req.b = vna_pkg::MUL_W'(r_d2[1]); end
            3'd2:    begin w_cross_req.a = vna_pkg::MUL_W'(r_d1[0]);
                           w_cross_req.b = vna_pkg::MUL_W'(r_d2[2]); end
            3'd3:    begin w_cross_req.a = vna_pkg::MUL_W'(r_d1[2]);
                           w_cross_req.b = vna_pkg::MUL_W'(r_d2[0]); end
            3'd4:    begin w_cross_req.a = vna_pkg::MUL_W'(r_d1[0]);
                           w_cross_req.b = vna_pkg::MUL_W'(r_d2[1]); end
            3'd5:    begin w_cross_req.a = vna_pkg::MUL_W'(r_d1[1]);
                           w_cross_req.b = vna_pkg::MUL_W'(r_d2[0]); end
            default: begin w_cross_req.a = '0;
                           w_cross_req.b = '0; end
        endcase
    end

    assign w_mul_req = (r_state == S_CROSS) ? w_cross_req : w_norm_req;

    vna_mul u_mul (
        .i_clk (i_clk),
        .i_req (w_mul_req),
        .o_p   (w_prod)
    );

    vna_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_nstart),
        .i_vec   (r_nvec),
        .o_done  (w_ndone),
        .o_res   (w_nres),
        .o_mul   (w_norm_req),
        .i_mul_p (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nstart    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_nstart    <= w_nstart;
            // load a new result when free, drop the old one once taken
            r_out_valid <= w_emit || (r_out_valid && !m_axis_tready);
            case (r_state)
                S_IDLE: begin
                    // capture the corners; loads finish in this cycle
                    if (w_in_acc) begin
                        r_slot[0] <= w_in_slot;
                        r_slot[1] <= AW'(s_axis_tdata[19:10] % vna_pkg::VERTEX_DEPTH);
                        r_slot[2] <= AW'(s_axis_tdata[29:20] % vna_pkg::VERTEX_DEPTH);
                        r_corner  <= '0;
                        if (s_axis_tuser == vna_pkg::OP_TRI) r_state <= S_RD0;
                    end
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin
                    r_pa    <= r_pos_rd;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_pb    <= r_pos_rd;
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_pc    <= r_pos_rd;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        r_d1[i] <= vna_pkg::DIFF_W'($signed(r_pb[24*i +: 24]))
                                 - vna_pkg::DIFF_W'($signed(r_pa[24*i +: 24]));
                        r_d2[i] <= vna_pkg::DIFF_W'($signed(r_pc[24*i +: 24]))
                                 - vna_pkg::DIFF_W'($signed(r_pa[24*i +: 24]));
                    end
                    r_cnt   <= '0;
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    // hold the first product of a pair, subtract the second
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt != '0) begin
                        if (!w_prev[0]) r_tmp <= w_prod_v;
                        else            r_nvec[w_prev[2:1]] <= r_tmp - w_prod_v;
                    end
                    if (r_cnt == 3'd6) r_state <= S_FACE;
                end
                S_FACE: begin
                    if (w_ndone) begin
                        r_face  <= w_nres;
                        r_state <= S_NRD;
                    end
                end
                S_NRD: r_state <= S_NCAP;
                S_NCAP: begin
                    for (int i = 0; i < 3; i++) begin
                        r_nvec[i] <= vna_pkg::VEC_W'(r_face[i])
                                   + vna_pkg::VEC_W'($signed(r_nrm_rd[16*i +: 16]));
                    end
                    r_state <= S_NSUM;
                end
                S_NSUM: begin
                    if (w_ndone) begin
                        r_out_data <= {6'd0, w_nres[2], w_nres[1], w_nres[0],
                                       vna_pkg::IDX_W'(r_slot[r_corner])};
                        r_out_last <= (r_corner == 2'd2);
                        r_state    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // advance once the output register is free
                    if (w_out_free) begin
                        if (r_corner == 2'd2) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_corner <= r_corner + 2'd1;
                            r_state  <= S_NRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register contents are staged in r_out_data until the emit step
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_m_data <= r_out_data;
            r_m_last <= r_out_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire
